[hdl/gcf_pkg.sv]
`default_nettype none

package gcf_pkg;

	localparam int COORD_W = 16;
	localparam int PROD_W  = 2 * (COORD_W + 1);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// Which of the four orientation tests an operation belongs to. The first two test the
	// new segment's endpoints against the stored line, the last two the reverse.
	typedef enum logic [1:0] {
		ORI_T_VS_SA,
		ORI_T_VS_SB,
		ORI_S_VS_TA,
		ORI_S_VS_TB
	} ori_sel_t;

	typedef struct packed {
		logic     valid;
		ori_sel_t sel;
		point_t   p;
		point_t   q;
		point_t   r;
	} ori_req_t;

	typedef struct packed {
		logic     valid;
		ori_sel_t sel;
		logic     pos;
		logic     neg;
	} ori_res_t;

endpackage

`default_nettype wire

[hdl/gcf_edge_mem.sv]
`default_nettype none

module gcf_edge_mem #(
	parameter int WIDTH = 78,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	assign rdata = rd_q;

endmodule

`default_nettype wire

[hdl/gcf_orient_unit.sv]
`default_nettype none

module gcf_orient_unit
	import gcf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ori_req_t req,
	output ori_res_t      res
);

	logic signed [COORD_W:0]   dqx, dqy, drx, dry;
	logic signed [PROD_W-1:0]  m1_s1, m2_s1;
	logic signed [PROD_W:0]    diff;
	logic                      valid_s1, valid_s2;
	ori_sel_t                  sel_s1, sel_s2;
	logic                      pos_s2, neg_s2;

	assign dqx = $signed({req.q.x[COORD_W-1], req.q.x}) - $signed({req.p.x[COORD_W-1], req.p.x});
	assign dqy = $signed({req.q.y[COORD_W-1], req.q.y}) - $signed({req.p.y[COORD_W-1], req.p.y});
	assign drx = $signed({req.r.x[COORD_W-1], req.r.x}) - $signed({req.p.x[COORD_W-1], req.p.x});
	assign dry = $signed({req.r.y[COORD_W-1], req.r.y}) - $signed({req.p.y[COORD_W-1], req.p.y});

	assign diff = $signed({m1_s1[PROD_W-1], m1_s1}) - $signed({m2_s1[PROD_W-1], m2_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1  <= PROD_W'(dqx) * PROD_W'(dry);
		m2_s1  <= PROD_W'(dqy) * PROD_W'(drx);
		sel_s1 <= req.sel;
		sel_s2 <= sel_s1;
		pos_s2 <= !diff[PROD_W] && (diff != '0);
		neg_s2 <= diff[PROD_W];
	end

	assign res.valid = valid_s2;
	assign res.sel   = sel_s2;
	assign res.pos   = pos_s2;
	assign res.neg   = neg_s2;

endmodule

`default_nettype wire

[hdl/greedy_edge_crossing_filter.sv]
// Each candidate edge is checked against the stored edges one at a time through a single
// shared orientation unit (two products, then a subtract), which runs four tests per stored
// edge; a stored edge that shares a node with the candidate skips the tests, and the scan
// stops at the first crossing. A new item is taken only once the previous result is in
// the output register.
// Reset empties the store at once; the edge memory is not cleared and needs no pass.
`default_nettype none

module greedy_edge_crossing_filter
	import gcf_pkg::*;
#(
	parameter int MAX_NODES = 128,
	parameter int MAX_EDGES = 512
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// end_a, end_b, a_x, a_y, b_x, b_y
	input  wire logic [((2*$clog2(MAX_NODES)+4*COORD_W+7)/8)*8-1:0] s_tdata,
	// new_frame
	input  wire logic                s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// edge_count
	output logic [(($clog2(MAX_EDGES+1)+7)/8)*8-1:0] m_tdata,
	// accepted, store_full
	output logic [1:0]               m_tuser
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int IDX_W  = $clog2(MAX_EDGES);
	localparam int CNT_W  = $clog2(MAX_EDGES + 1);
	localparam int ENT_W  = 2 * NODE_W + 4 * COORD_W;
	localparam int OUT_DW = ((CNT_W + 7) / 8) * 8;
	localparam int PB     = 2 * NODE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_ORI,
		S_WAIT,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [ENT_W-1:0]   seg_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   idx_nxt;
	ori_sel_t           sel_q;
	logic               hit_q;
	logic [2:0]         pos_q, neg_q;
	logic               out_valid_q, out_acc_q, out_full_q;
	logic [CNT_W-1:0]   out_cnt_q;

	logic [ENT_W-1:0]   rd_data;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_addr;
	logic               store_ok;
	logic               out_free;
	logic               shared;
	logic               crossing;
	logic               issue;
	point_t             s_a, s_b, t_a, t_b;
	logic [NODE_W-1:0]  s_na, s_nb, t_na, t_nb;
	ori_req_t           ori_req;
	ori_res_t           ori_res;

	assign s_na = seg_q[NODE_W-1:0];
	assign s_nb = seg_q[2*NODE_W-1:NODE_W];
	assign s_a  = '{x: seg_q[PB +: COORD_W], y: seg_q[PB+COORD_W +: COORD_W]};
	assign s_b  = '{x: seg_q[PB+2*COORD_W +: COORD_W], y: seg_q[PB+3*COORD_W +: COORD_W]};
	assign t_na = rd_data[NODE_W-1:0];
	assign t_nb = rd_data[2*NODE_W-1:NODE_W];
	assign t_a  = '{x: rd_data[PB +: COORD_W], y: rd_data[PB+COORD_W +: COORD_W]};
	assign t_b  = '{x: rd_data[PB+2*COORD_W +: COORD_W], y: rd_data[PB+3*COORD_W +: COORD_W]};

	assign shared = (s_na == t_na) || (s_na == t_nb) || (s_nb == t_na) || (s_nb == t_nb);
	assign issue  = (state_q == S_ORI) && !((sel_q == ORI_T_VS_SA) && shared);

	always_comb begin
		ori_req.valid = issue;
		ori_req.sel   = sel_q;
		case (sel_q)
			ORI_T_VS_SA: begin
				ori_req.p = t_a;
				ori_req.q = t_b;
				ori_req.r = s_a;
			end
			ORI_T_VS_SB: begin
				ori_req.p = t_a;
				ori_req.q = t_b;
				ori_req.r = s_b;
			end
			ORI_S_VS_TA: begin
				ori_req.p = s_a;
				ori_req.q = s_b;
				ori_req.r = t_a;
			end
			default: begin
				ori_req.p = s_a;
				ori_req.q = s_b;
				ori_req.r = t_b;
			end
		endcase
	end

	gcf_orient_unit u_orient (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ori_req),
		.res    (ori_res)
	);

	// A proper crossing needs strictly opposite signs on both pairs of tests.
	assign crossing = ((pos_q[0] && neg_q[1]) || (neg_q[0] && pos_q[1]))
		&& ((pos_q[2] && ori_res.neg) || (neg_q[2] && ori_res.pos));

	assign idx_nxt  = idx_q + CNT_W'(1);
	assign out_free = !out_valid_q || m_tready;
	assign store_ok = !hit_q && (count_q < CNT_W'(MAX_EDGES));
	assign mem_we   = (state_q == S_DONE) && out_free && store_ok;
	assign mem_addr = mem_we ? count_q[IDX_W-1:0] : idx_q[IDX_W-1:0];

	gcf_edge_mem #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_EDGES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (seg_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			sel_q       <= ORI_T_VS_SA;
			hit_q       <= 1'b0;
			pos_q       <= '0;
			neg_q       <= '0;
			out_valid_q <= 1'b0;
			out_acc_q   <= 1'b0;
			out_full_q  <= 1'b0;
			out_cnt_q   <= '0;
			seg_q       <= '0;
		end else begin
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (ori_res.valid) begin
				case (ori_res.sel)
					ORI_T_VS_SA: begin
						pos_q[0] <= ori_res.pos;
						neg_q[0] <= ori_res.neg;
					end
					ORI_T_VS_SB: begin
						pos_q[1] <= ori_res.pos;
						neg_q[1] <= ori_res.neg;
					end
					ORI_S_VS_TA: begin
						pos_q[2] <= ori_res.pos;
						neg_q[2] <= ori_res.neg;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						seg_q <= s_tdata[ENT_W-1:0];
						idx_q <= '0;
						hit_q <= 1'b0;
						if (s_tuser) begin
							count_q <= '0;
						end
						if (s_tuser || (count_q == '0)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					sel_q   <= ORI_T_VS_SA;
					state_q <= S_ORI;
				end
				S_ORI: begin
					if (!issue) begin
						// Edges that meet at a node are never counted as crossing.
						idx_q <= idx_nxt;
						state_q <= (idx_nxt == count_q) ? S_DONE : S_READ;
					end else begin
						case (sel_q)
							ORI_T_VS_SA: sel_q <= ORI_T_VS_SB;
							ORI_T_VS_SB: sel_q <= ORI_S_VS_TA;
							ORI_S_VS_TA: sel_q <= ORI_S_VS_TB;
							default:     state_q <= S_WAIT;
						endcase
					end
				end
				S_WAIT: begin
					if (ori_res.valid && (ori_res.sel == ORI_S_VS_TB)) begin
						if (crossing) begin
							hit_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							idx_q   <= idx_nxt;
							state_q <= (idx_nxt == count_q) ? S_DONE : S_READ;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_acc_q   <= store_ok;
						out_full_q  <= !hit_q && !store_ok;
						out_cnt_q   <= store_ok ? count_q + CNT_W'(1) : count_q;
						if (store_ok) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = OUT_DW'(out_cnt_q);
	assign m_tuser[0] = out_acc_q;
	assign m_tuser[1] = out_full_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_EDGES))
		else $error("stored edge count exceeds capacity");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("result both accepted and flagged full");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> out_cnt_q == CNT_W'(MAX_EDGES))
		else $error("store full reported below capacity");

	a_ori_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ori_res.valid |-> (state_q == S_ORI) || (state_q == S_WAIT))
		else $error("orientation result outside a scan");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !hit_q && (count_q < CNT_W'(MAX_EDGES)) && (state_q == S_DONE))
		else $error("edge written without room or after a crossing");

endmodule

`default_nettype wire
